>>> sv/stit_pkg.sv
package stit_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMITTED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  localparam int COEF_W = 32;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

endpackage

>>> sv/stit_cell.sv
module stit_cell #(
  parameter int KEY_W = 24
) (
  input  logic                       clk,
  input  stit_pkg::cell_ctl_t        ctl,
  input  logic                       occ,
  input  logic [KEY_W-1:0]           new_key,
  input  logic [stit_pkg::COEF_W-1:0] new_coef,
  input  logic                       prev_ge,
  input  logic [KEY_W-1:0]           prev_key,
  input  logic [stit_pkg::COEF_W-1:0] prev_coef,
  input  logic [KEY_W-1:0]           next_key,
  input  logic [stit_pkg::COEF_W-1:0] next_coef,
  output logic                       ge,
  output logic [KEY_W-1:0]           key,
  output logic [stit_pkg::COEF_W-1:0] coef
);

  logic [KEY_W-1:0]            key_r;
  logic [stit_pkg::COEF_W-1:0] coef_r;
  logic [KEY_W-1:0]            key_nxt;
  logic [stit_pkg::COEF_W-1:0] coef_nxt;

  // stored term stays ahead of the new one, ties keep arrival order
  assign ge = occ && (key_r >= new_key);

  always_comb begin
    key_nxt  = key_r;
    coef_nxt = coef_r;
    if (ctl.shift) begin
      key_nxt  = next_key;
      coef_nxt = next_coef;
    end else if (ctl.ins && !ge) begin
      if (prev_ge) begin
        key_nxt  = new_key;
        coef_nxt = new_coef;
      end else begin
        key_nxt  = prev_key;
        coef_nxt = prev_coef;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    coef_r <= coef_nxt;
  end

  assign key  = key_r;
  assign coef = coef_r;

endmodule

>>> sv/sorted_term_insert_table.sv
// Sorted term table: up to TABLE_DEPTH terms held in a row of cells in descending
// (x, y, z) exponent order, equal keys in arrival order. On an insert every cell
// compares its key with the new one at once and the row shifts to open the slot,
// giving one result beat (inserted, or dropped when full). A drain that is taken
// moves to S_DRAIN and then gives one beat per stored term: the row shifts toward
// cell 0 and each beat carries the head term, with last on the final one; an empty
// drain gives a single empty beat. No input is taken while a drain is streaming,
// and output stall holds the row. The input is also held off while a result beat
// waits under stall.
module sorted_term_insert_table #(
  parameter int TABLE_DEPTH   = 32,
  parameter int EXPONENT_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [stit_pkg::COEF_W-1:0]   in_coefficient,
  input  logic [EXPONENT_BITS-1:0]      in_exponent_x,
  input  logic [EXPONENT_BITS-1:0]      in_exponent_y,
  input  logic [EXPONENT_BITS-1:0]      in_exponent_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stit_pkg::STATUS_W-1:0] out_status,
  output logic [stit_pkg::COEF_W-1:0]   out_term_coefficient,
  output logic [EXPONENT_BITS-1:0]      out_term_exponent_x,
  output logic [EXPONENT_BITS-1:0]      out_term_exponent_y,
  output logic [EXPONENT_BITS-1:0]      out_term_exponent_z,
  output logic                          out_last
);

  localparam int KEY_W = 3 * EXPONENT_BITS;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  stit_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [stit_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [stit_pkg::COEF_W-1:0]   ocoef_r, ocoef_nxt;
  logic [KEY_W-1:0]              okey_r, okey_nxt;
  logic                          last_r, last_nxt;

  stit_pkg::cell_ctl_t ctl;
  logic [KEY_W-1:0]    new_key;
  logic                in_take, out_free, full;

  logic [TABLE_DEPTH-1:0]      occ;
  logic [TABLE_DEPTH-1:0]      ge;
  logic [KEY_W-1:0]            cell_key  [TABLE_DEPTH];
  logic [stit_pkg::COEF_W-1:0] cell_coef [TABLE_DEPTH];

  assign new_key  = {in_exponent_x, in_exponent_y, in_exponent_z};
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != stit_pkg::S_IDLE) || !out_free;
  assign in_take  = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(TABLE_DEPTH));

  assign ctl.ins   = in_take && (in_operation == stit_pkg::OP_INSERT) && !full;
  assign ctl.shift = (state_r == stit_pkg::S_DRAIN) && out_free;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                        p_ge;
    logic [KEY_W-1:0]            p_key, n_key;
    logic [stit_pkg::COEF_W-1:0] p_coef, n_coef;

    assign occ[i] = CNT_W'(i) < count_r;

    if (i == 0) begin : g_head
      assign p_ge   = 1'b1;
      assign p_key  = new_key;
      assign p_coef = in_coefficient;
    end else begin : g_body
      assign p_ge   = ge[i-1];
      assign p_key  = cell_key[i-1];
      assign p_coef = cell_coef[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign n_key  = '0;
      assign n_coef = '0;
    end else begin : g_inner
      assign n_key  = cell_key[i+1];
      assign n_coef = cell_coef[i+1];
    end

    stit_cell #(.KEY_W(KEY_W)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ[i]),
      .new_key   (new_key),
      .new_coef  (in_coefficient),
      .prev_ge   (p_ge),
      .prev_key  (p_key),
      .prev_coef (p_coef),
      .next_key  (n_key),
      .next_coef (n_coef),
      .ge        (ge[i]),
      .key       (cell_key[i]),
      .coef      (cell_coef[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    ocoef_nxt     = ocoef_r;
    okey_nxt      = okey_r;
    last_nxt      = last_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      stit_pkg::S_IDLE: begin
        if (in_take) begin
          out_valid_nxt = 1'b1;
          ocoef_nxt     = '0;
          okey_nxt      = '0;
          last_nxt      = 1'b1;
          if (in_operation == stit_pkg::OP_INSERT) begin
            if (full) begin
              status_nxt = stit_pkg::ST_DROPPED;
            end else begin
              status_nxt = stit_pkg::ST_INSERTED;
              count_nxt  = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            status_nxt = stit_pkg::ST_EMPTY;
          end else begin
            // first drain beat is registered from the head cell in S_DRAIN
            out_valid_nxt = 1'b0;
            state_nxt     = stit_pkg::S_DRAIN;
          end
        end
      end
      stit_pkg::S_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = stit_pkg::ST_EMITTED;
          ocoef_nxt     = cell_coef[0];
          okey_nxt      = cell_key[0];
          last_nxt      = (count_r == CNT_W'(1));
          count_nxt     = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            state_nxt = stit_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = stit_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stit_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    ocoef_r  <= ocoef_nxt;
    okey_r   <= okey_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_term_coefficient = ocoef_r;
  assign out_term_exponent_x  = okey_r[KEY_W-1 -: EXPONENT_BITS];
  assign out_term_exponent_y  = okey_r[2*EXPONENT_BITS-1 -: EXPONENT_BITS];
  assign out_term_exponent_z  = okey_r[EXPONENT_BITS-1:0];
  assign out_last             = last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("term count beyond table depth");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == stit_pkg::S_DRAIN |-> count_r != '0)
    else $error("drain running on empty table");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the table");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift && count_r == CNT_W'(1) |=> count_r == '0 && out_last
      && state_r == stit_pkg::S_IDLE)
    else $error("final drain beat did not empty the table");

endmodule
